[sv/nclx_pkg.sv]
// Shared types, character codes and token codes for the nested comment and string lexer.
// No dependencies; the front, back and top level use scoped names and the testbench imports it.
package nclx_pkg;

   // Default sizes handed to the top level's parameters.
   localparam int DEPTH_BITS_DEF  = 8;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int KIND_W = 7;

   // Character codes.
   localparam logic [7:0] CH_EOF     = 8'd0;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_NL      = 8'd10;
   localparam logic [7:0] CH_LPAREN  = 8'd40;
   localparam logic [7:0] CH_LSQUARE = 8'd91;
   localparam logic [7:0] CH_SLASH   = 8'd47;
   localparam logic [7:0] CH_STAR    = 8'd42;
   localparam logic [7:0] CH_SQUOTE  = 8'd39;
   localparam logic [7:0] CH_DQUOTE  = 8'd34;
   localparam logic [7:0] CH_BSLASH  = 8'd92;

   // Number of quotes that open or close a docstring.
   localparam logic [2:0] DOC_QUOTES = 3'd3;

   // Outcome codes.
   localparam logic [1:0] OUT_ACCEPT   = 2'd0;
   localparam logic [1:0] OUT_NOMATCH  = 2'd1;
   localparam logic [1:0] OUT_EOF      = 2'd2;
   localparam logic [1:0] OUT_OVERFLOW = 2'd3;

   // Token kind codes; the same numbers index the allowed kinds mask.
   localparam logic [2:0] KIND_COMMENT    = 3'd0;
   localparam logic [2:0] KIND_STRING     = 3'd1;
   localparam logic [2:0] KIND_CHAR       = 3'd2;
   localparam logic [2:0] KIND_PAREN      = 3'd3;
   localparam logic [2:0] KIND_PAREN_NL   = 3'd4;
   localparam logic [2:0] KIND_BRACKET    = 3'd5;
   localparam logic [2:0] KIND_BRACKET_NL = 3'd6;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_WS      = 4'd1,
      PH_COPEN   = 4'd2,
      PH_COMMENT = 4'd3,
      PH_CSLASH  = 4'd4,
      PH_CHAR    = 4'd5,
      PH_QUOTES  = 4'd6,
      PH_STR     = 4'd7,
      PH_DOC     = 4'd8,
      PH_DOCTAIL = 4'd9
   } phase_type;

   typedef struct packed {
      logic [7:0]        char_in;
      logic              scan_start;
      logic [KIND_W-1:0] allowed_kinds;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [2:0]  token_kind;
      logic        took_current;
      logic [15:0] token_length;
   } rsp_type;

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      logic              eof;
      logic              space;
      logic              newline;
      logic              lparen;
      logic              lsquare;
      logic              slash;
      logic              star;
      logic              squote;
      logic              dquote;
      logic              bslash;
      logic              scan_start;
      logic [KIND_W-1:0] kind_mask;
   } class_type;

endpackage

[sv/nclx_queue.sv]
// Short first-in first-out queue of register entries, used after the lexer's front and back.
// Depends on nothing but its type and depth parameters.
module nclx_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/nclx_front.sv]
// Front part of the lexer: accepts request beats and classifies each character.
// Depends on nclx_pkg; its output feeds the class queue.
module nclx_front (
   input  nclx_pkg::req_type   req_data,
   input  logic                req_push,
   output logic                req_full,
   input  logic                queue_full,
   output logic                queue_push,
   output nclx_pkg::class_type queue_data
);

   logic [7:0] ch;

   assign ch         = req_data.char_in;
   assign req_full   = queue_full;
   assign queue_push = req_push;

   always_comb begin
      queue_data            = '0;
      queue_data.eof        = (ch == nclx_pkg::CH_EOF);
      queue_data.space      = (ch == nclx_pkg::CH_SPACE) ||
                              (ch >= nclx_pkg::CH_TAB && ch <= nclx_pkg::CH_CR);
      queue_data.newline    = (ch == nclx_pkg::CH_NL);
      queue_data.lparen     = (ch == nclx_pkg::CH_LPAREN);
      queue_data.lsquare    = (ch == nclx_pkg::CH_LSQUARE);
      queue_data.slash      = (ch == nclx_pkg::CH_SLASH);
      queue_data.star       = (ch == nclx_pkg::CH_STAR);
      queue_data.squote     = (ch == nclx_pkg::CH_SQUOTE);
      queue_data.dquote     = (ch == nclx_pkg::CH_DQUOTE);
      queue_data.bslash     = (ch == nclx_pkg::CH_BSLASH);
      queue_data.scan_start = req_data.scan_start;
      queue_data.kind_mask  = req_data.allowed_kinds;
   end

endmodule

[sv/nclx_back.sv]
// Back part of the lexer: the scan state machine that consumes classified characters.
// Depends on nclx_pkg; reads the class queue and writes the result queue.
module nclx_back #(
   parameter int DEPTH_BITS  = nclx_pkg::DEPTH_BITS_DEF,
   parameter int LENGTH_BITS = nclx_pkg::LENGTH_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_empty,
   input  nclx_pkg::class_type in_data,
   output logic                in_pop,
   input  logic                out_full,
   output logic                out_push,
   output nclx_pkg::rsp_type   out_data
);

   nclx_pkg::phase_type       phase_ff, phase_in;
   logic                      newline_ff, newline_in;
   logic [DEPTH_BITS-1:0]     depth_ff, depth_in;
   logic                      star_ff, star_in;
   logic                      esc_ff, esc_in;
   logic [1:0]                qrun_ff, qrun_in;
   logic [LENGTH_BITS-1:0]    len_ff, len_in;
   logic [nclx_pkg::KIND_W-1:0] mask_ff, mask_in;

   // Values after a scan start has been applied.
   nclx_pkg::phase_type       ph, ph_sel;
   logic [DEPTH_BITS-1:0]     depth_c;
   logic                      star_c, esc_c;
   logic [1:0]                qrun_c;
   logic [LENGTH_BITS-1:0]    len_c;
   logic [nclx_pkg::KIND_W-1:0] mask_c;
   logic [2:0]                qinc;
   logic                      fire, fin, took, term, cons;
   logic [1:0]                f_outcome;
   logic [2:0]                f_kind, str_kind;

   assign fire   = !in_empty && !out_full;
   assign in_pop = fire;

   always_comb begin
      ph      = in_data.scan_start ? nclx_pkg::PH_WS : phase_ff;
      mask_c  = in_data.scan_start ? in_data.kind_mask : mask_ff;
      len_c   = in_data.scan_start ? '0 : len_ff;
      depth_c = in_data.scan_start ? '0 : depth_ff;
      star_c  = in_data.scan_start ? 1'b0 : star_ff;
      esc_c   = in_data.scan_start ? 1'b0 : esc_ff;
      qrun_c  = in_data.scan_start ? 2'd0 : qrun_ff;

      // A slash in a comment that is not followed by a star, and a quote run that
      // turns out to be a plain string, both handle the same character again.
      ph_sel = ph;
      if (ph == nclx_pkg::PH_CSLASH && !in_data.star) begin
         ph_sel = nclx_pkg::PH_COMMENT;
      end
      if (ph == nclx_pkg::PH_QUOTES && !in_data.dquote && qrun_c != 2'd2) begin
         ph_sel = nclx_pkg::PH_STR;
         qrun_c = 2'd0;
         esc_c  = 1'b0;
      end

      phase_in   = ph_sel;
      newline_in = newline_ff;
      depth_in   = depth_c;
      star_in    = star_c;
      esc_in     = esc_c;
      qrun_in    = qrun_c;
      mask_in    = mask_c;
      cons       = 1'b0;
      fin        = 1'b0;
      took       = 1'b0;
      f_outcome  = nclx_pkg::OUT_ACCEPT;
      f_kind     = nclx_pkg::KIND_COMMENT;
      qinc       = {1'b0, qrun_c} + 3'd1;
      term       = (ph_sel == nclx_pkg::PH_CHAR) ? in_data.squote : in_data.dquote;
      str_kind   = (ph_sel == nclx_pkg::PH_CHAR) ? nclx_pkg::KIND_CHAR : nclx_pkg::KIND_STRING;

      case (ph_sel)
         nclx_pkg::PH_IDLE: begin
         end
         nclx_pkg::PH_WS: begin
            if (in_data.space) begin
               if (in_data.newline) begin
                  newline_in = 1'b1;
               end
            end else if (in_data.lparen && (mask_c[nclx_pkg::KIND_PAREN] ||
                                            mask_c[nclx_pkg::KIND_PAREN_NL])) begin
               f_kind     = newline_ff ? nclx_pkg::KIND_PAREN_NL : nclx_pkg::KIND_PAREN;
               newline_in = 1'b0;
               fin        = 1'b1;
               took       = 1'b1;
            end else if (in_data.lsquare && (mask_c[nclx_pkg::KIND_BRACKET] ||
                                             mask_c[nclx_pkg::KIND_BRACKET_NL])) begin
               f_kind     = newline_ff ? nclx_pkg::KIND_BRACKET_NL : nclx_pkg::KIND_BRACKET;
               newline_in = 1'b0;
               fin        = 1'b1;
               took       = 1'b1;
            end else begin
               newline_in = 1'b0;
               if (mask_c[nclx_pkg::KIND_COMMENT] && in_data.slash) begin
                  cons     = 1'b1;
                  phase_in = nclx_pkg::PH_COPEN;
               end else if (mask_c[nclx_pkg::KIND_CHAR] && in_data.squote) begin
                  cons     = 1'b1;
                  esc_in   = 1'b0;
                  phase_in = nclx_pkg::PH_CHAR;
               end else if (mask_c[nclx_pkg::KIND_STRING] && in_data.dquote) begin
                  cons     = 1'b1;
                  qrun_in  = 2'd1;
                  phase_in = nclx_pkg::PH_QUOTES;
               end else begin
                  fin       = 1'b1;
                  f_outcome = nclx_pkg::OUT_NOMATCH;
               end
            end
         end
         nclx_pkg::PH_COPEN: begin
            if (!in_data.star) begin
               fin       = 1'b1;
               f_outcome = nclx_pkg::OUT_NOMATCH;
            end else begin
               cons     = 1'b1;
               depth_in = DEPTH_BITS'(1);
               star_in  = 1'b0;
               phase_in = nclx_pkg::PH_COMMENT;
            end
         end
         nclx_pkg::PH_CSLASH: begin
            // Only reached here with a star: it opens a nested level unless the depth is full.
            if (depth_c == '1) begin
               fin       = 1'b1;
               f_outcome = nclx_pkg::OUT_OVERFLOW;
            end else begin
               depth_in = depth_c + 1'b1;
               cons     = 1'b1;
               star_in  = 1'b0;
               phase_in = nclx_pkg::PH_COMMENT;
            end
         end
         nclx_pkg::PH_COMMENT: begin
            if (in_data.eof) begin
               fin       = 1'b1;
               f_outcome = nclx_pkg::OUT_EOF;
            end else if (in_data.star) begin
               cons    = 1'b1;
               star_in = 1'b1;
            end else if (in_data.slash) begin
               if (star_c) begin
                  star_in = 1'b0;
                  if (depth_c <= DEPTH_BITS'(1)) begin
                     depth_in = '0;
                     fin      = 1'b1;
                     took     = 1'b1;
                  end else begin
                     cons     = 1'b1;
                     depth_in = depth_c - 1'b1;
                  end
               end else begin
                  cons     = 1'b1;
                  phase_in = nclx_pkg::PH_CSLASH;
               end
            end else begin
               cons    = 1'b1;
               star_in = 1'b0;
            end
         end
         nclx_pkg::PH_CHAR, nclx_pkg::PH_STR: begin
            if (in_data.eof) begin
               fin       = 1'b1;
               f_outcome = nclx_pkg::OUT_EOF;
            end else if (in_data.bslash) begin
               cons   = 1'b1;
               esc_in = !esc_c;
            end else if (term) begin
               if (!esc_c) begin
                  fin    = 1'b1;
                  took   = 1'b1;
                  f_kind = str_kind;
               end else begin
                  cons   = 1'b1;
                  esc_in = 1'b0;
               end
            end else begin
               cons   = 1'b1;
               esc_in = 1'b0;
            end
         end
         nclx_pkg::PH_QUOTES: begin
            if (in_data.dquote) begin
               cons = 1'b1;
               if (qinc >= nclx_pkg::DOC_QUOTES) begin
                  qrun_in  = 2'd0;
                  phase_in = nclx_pkg::PH_DOC;
               end else begin
                  qrun_in = qinc[1:0];
               end
            end else begin
               // Two quotes and then something else: the empty string.
               qrun_in = 2'd0;
               fin     = 1'b1;
               f_kind  = nclx_pkg::KIND_STRING;
            end
         end
         nclx_pkg::PH_DOC: begin
            if (in_data.dquote) begin
               cons = 1'b1;
               if (qinc >= nclx_pkg::DOC_QUOTES) begin
                  qrun_in  = 2'd0;
                  phase_in = nclx_pkg::PH_DOCTAIL;
               end else begin
                  qrun_in = qinc[1:0];
               end
            end else begin
               qrun_in = 2'd0;
               if (in_data.eof) begin
                  fin       = 1'b1;
                  f_outcome = nclx_pkg::OUT_EOF;
               end else begin
                  cons = 1'b1;
               end
            end
         end
         nclx_pkg::PH_DOCTAIL: begin
            if (in_data.dquote) begin
               cons = 1'b1;
            end else begin
               fin    = 1'b1;
               f_kind = nclx_pkg::KIND_STRING;
            end
         end
         default: begin
            phase_in = nclx_pkg::PH_IDLE;
         end
      endcase

      len_in = len_c;
      if ((cons || took) && len_c != '1) begin
         len_in = len_c + 1'b1;
      end
      if (fin) begin
         phase_in = nclx_pkg::PH_IDLE;
      end

      out_push              = fire && fin;
      out_data.outcome      = f_outcome;
      out_data.token_kind   = (f_outcome == nclx_pkg::OUT_ACCEPT) ? f_kind :
                              nclx_pkg::KIND_COMMENT;
      out_data.took_current = took;
      out_data.token_length = ((len_in >> 16) != '0) ? 16'hFFFF : 16'(len_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= nclx_pkg::PH_IDLE;
         newline_ff <= 1'b0;
         depth_ff   <= '0;
         star_ff    <= 1'b0;
         esc_ff     <= 1'b0;
         qrun_ff    <= 2'd0;
         len_ff     <= '0;
         mask_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         newline_ff <= newline_in;
         depth_ff   <= depth_in;
         star_ff    <= star_in;
         esc_ff     <= esc_in;
         qrun_ff    <= qrun_in;
         len_ff     <= len_in;
         mask_ff    <= mask_in;
      end
   end

endmodule

[sv/nested_comment_string_lexer_top.sv]
// Request beats are classified combinationally on entry to the class queue register.
// Throughput: one character beat per cycle while a beat waits and the response queue has room.
// Each class queue and response queue holds QUEUE_DEPTH beats, so either side may stall alone.
// Synchronous active-high reset empties both queues and returns the scanner to idle with the
// newline flag, nesting depth, escape, quote run, length and kind mask cleared.
// Depends on nclx_pkg, nclx_front, nclx_queue and nclx_back.
module nested_comment_string_lexer_top #(
   parameter int DEPTH_BITS  = nclx_pkg::DEPTH_BITS_DEF,
   parameter int LENGTH_BITS = nclx_pkg::LENGTH_BITS_DEF,
   parameter int QUEUE_DEPTH = nclx_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  nclx_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output nclx_pkg::rsp_type rsp_data
);

   // Classified characters waiting for the scanner.
   logic                class_push, class_full, class_empty, class_pop;
   nclx_pkg::class_type class_in, class_out;

   // Finished responses waiting for the consumer.
   logic                resp_push, resp_full;
   nclx_pkg::rsp_type   resp_in;

   // The front classifies each character as it is accepted, so the back only
   // ever looks at a handful of flag bits.
   nclx_front u_front (
      .req_data   (req_data),
      .req_push   (req_push),
      .req_full   (req_full),
      .queue_full (class_full),
      .queue_push (class_push),
      .queue_data (class_in)
   );

   nclx_queue #(
      .item_type (nclx_pkg::class_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (class_push),
      .push_data (class_in),
      .full      (class_full),
      .pop       (class_pop),
      .empty     (class_empty),
      .pop_data  (class_out)
   );

   // The back takes one character beat per cycle whenever the class queue holds one and the
   // response queue has room, whether or not that character ends the scan.
   nclx_back #(
      .DEPTH_BITS  (DEPTH_BITS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_empty (class_empty),
      .in_data  (class_out),
      .in_pop   (class_pop),
      .out_full (resp_full),
      .out_push (resp_push),
      .out_data (resp_in)
   );

   nclx_queue #(
      .item_type (nclx_pkg::rsp_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_resp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (resp_push),
      .push_data (resp_in),
      .full      (resp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

endmodule

[tb/sv/tb.sv]
// Testbench for the nested comment and string lexer: character beats in, token results out.
// Depends on nclx_pkg and nested_comment_string_lexer_top; the expected tokens come from a
// scanner model kept inside this file.
`timescale 1ns / 100ps

module tb;
   import nclx_pkg::*;

   typedef logic [7:0] char_q_type[$];

   // Vertical tab and form feed also count as blanks ahead of a token.
   localparam logic [7:0] CH_VT = 8'd11;
   localparam logic [7:0] CH_FF = 8'd12;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   nested_comment_string_lexer_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Character beats waiting to be offered, and the tokens the scanner model says must come out.
   req_type pending_beats[$];
   rsp_type expected_tokens[$];

   int queued_beats   = 0;
   int beats_accepted = 0;
   int tokens_seen    = 0;
   int mismatch_count = 0;

   // Scanner model state. It starts out in its reset state, since reset is applied only once.
   phase_type         lex_phase   = PH_IDLE;
   logic              nl_pending  = 1'b0;
   logic [7:0]        nest_level  = '0;
   logic              star_seen   = 1'b0;
   logic              in_escape   = 1'b0;
   logic [1:0]        dq_run      = '0;
   logic [15:0]       tok_len     = '0;
   logic [KIND_W-1:0] kind_allow  = '0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("tb: mismatch at %0t ns: %s", $time, what);
   endtask

   // The token length saturates at the top of its 16-bit range.
   task automatic bump_len();
      if (tok_len != '1)
         tok_len++;
   endtask

   // Ends the scan and queues the one result that every finished scan gives.
   task automatic close_token(input logic [1:0] outcome, input logic [2:0] kind,
                              input logic took);
      rsp_type r;
      if (took)
         bump_len();
      r.outcome      = outcome;
      // The kind reads as zero on any outcome other than an accepted token.
      r.token_kind   = (outcome == OUT_ACCEPT) ? kind : KIND_COMMENT;
      r.took_current = took;
      r.token_length = tok_len;
      expected_tokens.push_back(r);
      lex_phase = PH_IDLE;
   endtask

   // Advances the scanner model by one accepted character beat.
   task automatic lex_char(input req_type r);
      logic [7:0] c;
      logic [7:0] term;
      logic [2:0] kind;
      logic       again;
      c = r.char_in;
      // A start beat opens a fresh scan, dropping any scan in progress. The newline flag stays.
      if (r.scan_start) begin
         lex_phase   = PH_WS;
         kind_allow  = r.allowed_kinds;
         tok_len     = '0;
         nest_level  = '0;
         star_seen   = 1'b0;
         in_escape   = 1'b0;
         dq_run      = '0;
      end
      // Some phases hand the same character on to the next phase, hence the loop.
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (lex_phase)
            PH_WS: begin
               if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                  if (c == CH_NL)
                     nl_pending = 1'b1;
               end else if (c == CH_LPAREN &&
                            (kind_allow[KIND_PAREN] || kind_allow[KIND_PAREN_NL])) begin
                  close_token(OUT_ACCEPT, nl_pending ? KIND_PAREN_NL : KIND_PAREN, 1'b1);
                  nl_pending = 1'b0;
               end else if (c == CH_LSQUARE &&
                            (kind_allow[KIND_BRACKET] || kind_allow[KIND_BRACKET_NL])) begin
                  close_token(OUT_ACCEPT, nl_pending ? KIND_BRACKET_NL : KIND_BRACKET, 1'b1);
                  nl_pending = 1'b0;
               end else begin
                  nl_pending = 1'b0;
                  if (kind_allow[KIND_COMMENT] && c == CH_SLASH) begin
                     bump_len();
                     lex_phase = PH_COPEN;
                  end else if (kind_allow[KIND_CHAR] && c == CH_SQUOTE) begin
                     bump_len();
                     in_escape = 1'b0;
                     lex_phase = PH_CHAR;
                  end else if (kind_allow[KIND_STRING] && c == CH_DQUOTE) begin
                     bump_len();
                     dq_run    = 2'd1;
                     lex_phase = PH_QUOTES;
                  end else begin
                     close_token(OUT_NOMATCH, KIND_COMMENT, 1'b0);
                  end
               end
            end
            PH_COPEN: begin
               if (c != CH_STAR) begin
                  close_token(OUT_NOMATCH, KIND_COMMENT, 1'b0);
               end else begin
                  bump_len();
                  nest_level = 8'd1;
                  star_seen  = 1'b0;
                  lex_phase  = PH_COMMENT;
               end
            end
            PH_CSLASH: begin
               if (c == CH_STAR) begin
                  if (nest_level == '1) begin
                     close_token(OUT_OVERFLOW, KIND_COMMENT, 1'b0);
                  end else begin
                     nest_level++;
                     bump_len();
                     star_seen = 1'b0;
                     lex_phase = PH_COMMENT;
                  end
               end else begin
                  lex_phase = PH_COMMENT;
                  again     = 1'b1;
               end
            end
            PH_COMMENT: begin
               if (c == CH_EOF) begin
                  close_token(OUT_EOF, KIND_COMMENT, 1'b0);
               end else if (c == CH_STAR) begin
                  bump_len();
                  star_seen = 1'b1;
               end else if (c == CH_SLASH) begin
                  if (star_seen) begin
                     star_seen = 1'b0;
                     if (nest_level <= 8'd1) begin
                        nest_level = '0;
                        close_token(OUT_ACCEPT, KIND_COMMENT, 1'b1);
                     end else begin
                        bump_len();
                        nest_level--;
                     end
                  end else begin
                     bump_len();
                     lex_phase = PH_CSLASH;
                  end
               end else begin
                  bump_len();
                  star_seen = 1'b0;
               end
            end
            PH_CHAR, PH_STR: begin
               term = (lex_phase == PH_CHAR) ? CH_SQUOTE : CH_DQUOTE;
               kind = (lex_phase == PH_CHAR) ? KIND_CHAR : KIND_STRING;
               if (c == CH_EOF) begin
                  close_token(OUT_EOF, KIND_COMMENT, 1'b0);
               end else if (c == CH_BSLASH) begin
                  bump_len();
                  in_escape = ~in_escape;
               end else if (c == term && !in_escape) begin
                  close_token(OUT_ACCEPT, kind, 1'b1);
               end else begin
                  bump_len();
                  in_escape = 1'b0;
               end
            end
            PH_QUOTES: begin
               if (c == CH_DQUOTE) begin
                  bump_len();
                  dq_run++;
                  if (dq_run >= DOC_QUOTES) begin
                     dq_run    = '0;
                     lex_phase = PH_DOC;
                  end
               end else if (dq_run == 2'd2) begin
                  // Two quotes and then something else: the empty string.
                  dq_run = '0;
                  close_token(OUT_ACCEPT, KIND_STRING, 1'b0);
               end else begin
                  dq_run    = '0;
                  in_escape = 1'b0;
                  lex_phase = PH_STR;
                  again     = 1'b1;
               end
            end
            PH_DOC: begin
               if (c == CH_DQUOTE) begin
                  bump_len();
                  dq_run++;
                  if (dq_run >= DOC_QUOTES) begin
                     dq_run    = '0;
                     lex_phase = PH_DOCTAIL;
                  end
               end else begin
                  dq_run = '0;
                  if (c == CH_EOF)
                     close_token(OUT_EOF, KIND_COMMENT, 1'b0);
                  else
                     bump_len();
               end
            end
            PH_DOCTAIL: begin
               if (c == CH_DQUOTE)
                  bump_len();
               else
                  close_token(OUT_ACCEPT, KIND_STRING, 1'b0);
            end
            default: begin
               // Idle: characters without a start mark are ignored.
               lex_phase = PH_IDLE;
            end
         endcase
      end
   endtask

   // Both channels are sampled here, at the rising edge, before the block's outputs move on.
   // The request side feeds the model; the response side is checked against its oldest entry.
   logic req_taken = 1'b0;

   always @(posedge clock) begin
      rsp_type want;
      req_taken = !reset && req_push && !req_full;
      if (req_taken) begin
         beats_accepted++;
         lex_char(req_data);
      end
      if (!reset && rsp_pop && !rsp_empty) begin
         tokens_seen++;
         if (expected_tokens.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected: %p", rsp_data));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_data.outcome !== want.outcome)
               report_mismatch($sformatf("result %0d outcome %0d, expected %0d",
                  tokens_seen, rsp_data.outcome, want.outcome));
            if (rsp_data.token_kind !== want.token_kind)
               report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                  tokens_seen, rsp_data.token_kind, want.token_kind));
            if (rsp_data.took_current !== want.took_current)
               report_mismatch($sformatf("result %0d took_current %0d, expected %0d",
                  tokens_seen, rsp_data.took_current, want.took_current));
            if (rsp_data.token_length !== want.token_length)
               report_mismatch($sformatf("result %0d length %0d, expected %0d",
                  tokens_seen, rsp_data.token_length, want.token_length));
         end
      end
   end

   // Sender: offers queued beats in bursts of random length, with random gaps between them.
   // A gap of zero joins two bursts, so long runs without idling occur as well.
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            req_data <= pending_beats.pop_front();
            req_push <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 60);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver: pop follows a pattern set by the top bits of a free-running step counter, from
   // always ready to mostly stalled. Once, after about a dozen results, it holds off for a long
   // stretch while the sender keeps going, so that both internal queues fill and req_full rises.
   logic [8:0] stall_step = '0;
   int         hold_left  = 0;
   logic       hold_done  = 1'b0;

   always @(negedge clock) begin
      stall_step <= stall_step + 9'd1;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else if (!hold_done && tokens_seen >= 12) begin
         hold_left <= 400;
         hold_done <= 1'b1;
         rsp_pop   <= 1'b0;
      end else begin
         case (stall_step[8:6])
            3'd0, 3'd1: rsp_pop <= 1'b1;
            3'd2:       rsp_pop <= (stall_step[1:0] == 2'd0);
            3'd3:       rsp_pop <= ($urandom_range(0, 3) == 0);
            default:    rsp_pop <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic logic [7:0] text_char(input logic [7:0] skip_a, input logic [7:0] skip_b);
      logic [7:0] c;
      do
         c = 8'($urandom_range(1, 255));
      while (c == skip_a || c == skip_b);
      return c;
   endfunction

   // Mostly short token bodies, now and then a longer one.
   function automatic int body_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
   endfunction

   task automatic queue_beat(input logic [7:0] c, input logic start, input logic [6:0] mask);
      req_type r;
      r.char_in       = c;
      r.scan_start    = start;
      r.allowed_kinds = mask;
      pending_beats.push_back(r);
      queued_beats++;
   endtask

   // Queues one scan: the first beat carries the start mark and the kind mask, the mask on the
   // later beats is random since the block takes it only at the start.
   task automatic queue_scan(input logic [6:0] mask, input char_q_type seq);
      foreach (seq[i])
         queue_beat(seq[i], i == 0, (i == 0) ? mask : 7'($urandom_range(0, 127)));
   endtask

   // Builds one random scan. Most are well formed tokens with random content; some are cut
   // short (so the next start lands inside them) or end in an end-of-input byte, and a few are
   // plain noise.
   task automatic queue_token();
      char_q_type seq;
      logic [6:0] need;
      logic [7:0] term;
      int         pick;
      int         depth;
      int         n;
      seq  = {};
      need = '0;
      if ($urandom_range(0, 1) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0: seq.push_back(CH_SPACE);
               1: seq.push_back(CH_TAB);
               2: seq.push_back(CH_NL);
               3: seq.push_back(CH_VT);
               4: seq.push_back(CH_FF);
               default: seq.push_back(CH_CR);
            endcase
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         need = 7'd1 << $urandom_range(KIND_PAREN, KIND_BRACKET_NL);
         seq.push_back(($urandom_range(0, 1) == 0) ? CH_LPAREN : CH_LSQUARE);
      end else if (pick < 34) begin
         // Nested comment with random levels, stars and slashes in its text.
         need = 7'd1 << KIND_COMMENT;
         seq.push_back(CH_SLASH);
         seq.push_back(CH_STAR);
         depth = 1;
         n = body_len();
         repeat (n) begin
            case ($urandom_range(0, 7))
               0: if (depth < 6) begin
                  seq.push_back(CH_SLASH);
                  seq.push_back(CH_STAR);
                  depth++;
               end
               1: if (depth > 1) begin
                  seq.push_back(CH_STAR);
                  seq.push_back(CH_SLASH);
                  depth--;
               end
               2: begin
                  seq.push_back(CH_STAR);
                  seq.push_back(text_char(CH_SLASH, CH_STAR));
               end
               3: begin
                  seq.push_back(CH_SLASH);
                  seq.push_back(text_char(CH_STAR, CH_STAR));
               end
               default: seq.push_back(text_char(CH_STAR, CH_SLASH));
            endcase
         end
         repeat (depth) begin
            seq.push_back(CH_STAR);
            seq.push_back(CH_SLASH);
         end
      end else if (pick < 62) begin
         // Character literal or plain string; escapes come as backslash plus any nonzero byte.
         term = (pick < 46) ? CH_SQUOTE : CH_DQUOTE;
         need = 7'd1 << ((pick < 46) ? KIND_CHAR : KIND_STRING);
         seq.push_back(term);
         n = body_len();
         repeat (n) begin
            if ($urandom_range(0, 6) == 0) begin
               seq.push_back(CH_BSLASH);
               seq.push_back(text_char(CH_EOF, CH_EOF));
            end else begin
               seq.push_back(text_char(term, CH_BSLASH));
            end
         end
         seq.push_back(term);
      end else if (pick < 68) begin
         need = 7'd1 << KIND_STRING;
         seq.push_back(CH_DQUOTE);
         seq.push_back(CH_DQUOTE);
         seq.push_back(($urandom_range(0, 4) == 0) ? CH_EOF : text_char(CH_DQUOTE, CH_DQUOTE));
      end else if (pick < 78) begin
         need = 7'd1 << KIND_STRING;
         repeat (DOC_QUOTES) seq.push_back(CH_DQUOTE);
         n = body_len();
         repeat (n) begin
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 2)) seq.push_back(CH_DQUOTE);
            seq.push_back(text_char(CH_DQUOTE, CH_DQUOTE));
         end
         repeat (DOC_QUOTES) seq.push_back(CH_DQUOTE);
         repeat ($urandom_range(0, 3)) seq.push_back(CH_DQUOTE);
         seq.push_back(($urandom_range(0, 4) == 0) ? CH_EOF : text_char(CH_DQUOTE, CH_DQUOTE));
      end else if (pick < 84) begin
         need = 7'd1 << KIND_COMMENT;
         seq.push_back(CH_SLASH);
         seq.push_back(($urandom_range(0, 4) == 0) ? CH_EOF : text_char(CH_STAR, CH_STAR));
      end else if (pick < 91) begin
         seq.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 6);
         repeat (n)
            queue_beat(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                       7'($urandom_range(0, 127)));
         return;
      end
      if (pick >= 14 && pick < 78) begin
         case ($urandom_range(0, 19))
            0: seq = seq[0:$urandom_range(0, seq.size() - 1)];
            1: begin
               seq = seq[0:$urandom_range(0, seq.size() - 1)];
               seq.push_back(CH_EOF);
            end
            default: ;
         endcase
      end
      queue_scan(($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127))
                                               : (7'($urandom_range(0, 127)) | need), seq);
   endtask

   // The stimulus sequence waits here until every queued beat is in and every expected token is out.
   task automatic wait_drained();
      while (beats_accepted != queued_beats || expected_tokens.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      char_q_type seq;
      int         target;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed scans, one per special case: plain paren, bracket after a newline, slash with
      // no star behind it, a character literal whose escaped quote is not its end, the empty
      // string, a docstring with extra closing quotes, end of input inside a string, a start
      // that drops an open literal, a paren with only its newline kind, and a stray idle beat.
      seq = {CH_LPAREN};
      queue_scan(7'h7F, seq);
      seq = {CH_NL, CH_LSQUARE};
      queue_scan(7'h7F, seq);
      seq = {CH_SLASH, 8'h78};
      queue_scan(7'h7F, seq);
      seq = {CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE};
      queue_scan(7'h7F, seq);
      seq = {CH_DQUOTE, CH_DQUOTE, 8'h61};
      queue_scan(7'h7F, seq);
      seq = {CH_DQUOTE, CH_DQUOTE, CH_DQUOTE, 8'h78, CH_DQUOTE, CH_DQUOTE, CH_DQUOTE,
             CH_DQUOTE, 8'h7A};
      queue_scan(7'h7F, seq);
      seq = {CH_DQUOTE, 8'h61, CH_EOF};
      queue_scan(7'h7F, seq);
      seq = {CH_SQUOTE, 8'h61};
      queue_scan(7'h7F, seq);
      seq = {CH_LPAREN};
      queue_scan(7'd1 << KIND_PAREN_NL, seq);
      queue_beat(8'hFF, 1'b0, 7'h7F);
      wait_drained();

      // Random scans; the receiver's long hold-off falls in this stretch.
      target = queued_beats + 110;
      while (queued_beats < target)
         queue_token();
      wait_drained();

      // Nesting overflow: the 256th level does not fit in eight bits of depth.
      seq = {};
      repeat (256) begin
         seq.push_back(CH_SLASH);
         seq.push_back(CH_STAR);
      end
      queue_scan(7'd1 << KIND_COMMENT, seq);
      wait_drained();

      target = queued_beats + 110;
      while (queued_beats < target)
         queue_token();
      wait_drained();

      // Allow for any result that should not exist to show up before the verdict.
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
sv/nclx_pkg.sv
sv/nclx_queue.sv
sv/nclx_front.sv
sv/nclx_back.sv
sv/nested_comment_string_lexer_top.sv
tb/sv/tb.sv
